// ===== rtl/iufb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// iufb_pkg
// Shared types and constants for the IPv4/UDP frame builder.
// ============================================================================
package iufb_pkg;

    localparam int MAX_PAYLOAD = 1472;
    localparam int MAX_FRAME   = 1514;
    localparam int HDR_LEN     = 42;
    localparam int IP_HDR_LEN  = 20;
    localparam int UDP_HDR_LEN = 8;
    localparam int ETH_HDR_LEN = 14;

    localparam logic [10:0] CAPACITY_RESET = 11'd1514;

    localparam logic [7:0] ETH_TYPE_HI   = 8'h08;
    localparam logic [7:0] ETH_TYPE_LO   = 8'h00;
    localparam logic [7:0] IP_VER_IHL    = 8'h45;
    localparam logic [7:0] IP_TTL        = 8'd64;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;
    localparam logic [19:0] IP_CONST_SUM = 20'h04500 + 20'h04011;

    // op codes (tuser on the input side)
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // status codes (tuser on the output side)
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // register indexes
    localparam logic [2:0] REG_SOURCE_MAC       = 3'd0;
    localparam logic [2:0] REG_DESTINATION_MAC  = 3'd1;
    localparam logic [2:0] REG_SOURCE_IP        = 3'd2;
    localparam logic [2:0] REG_DESTINATION_IP   = 3'd3;
    localparam logic [2:0] REG_SOURCE_PORT      = 3'd4;
    localparam logic [2:0] REG_DESTINATION_PORT = 3'd5;
    localparam logic [2:0] REG_FRAME_CAPACITY   = 3'd6;

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] destination_mac;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [10:0] frame_capacity;
        logic [19:0] ip_sum;          // constant header words plus addresses
    } cfg_t;

    typedef struct packed {
        logic [10:0] ip_len;
        logic [10:0] udp_len;
        logic [15:0] checksum;
    } hdr_t;

    typedef enum logic {
        ST_IDLE,
        ST_HEADER
    } state_t;

endpackage

// ===== rtl/iufb_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// iufb_cfg_regs
// Configuration register file with a registered partial IPv4 checksum sum.
// ============================================================================
module iufb_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [47:0]          cfg_data,
    output iufb_pkg::cfg_t       cfg
);
    import iufb_pkg::*;

    logic [47:0] source_mac_reg;
    logic [47:0] destination_mac_reg;
    logic [31:0] source_ip_reg;
    logic [31:0] source_ip_next;
    logic [31:0] destination_ip_reg;
    logic [31:0] destination_ip_next;
    logic [15:0] source_port_reg;
    logic [15:0] destination_port_reg;
    logic [10:0] frame_capacity_reg;
    logic [19:0] ip_sum_reg;
    logic [19:0] ip_sum_next;

    // sum tracks the address values being written so it never lags them
    always_comb
    begin
        source_ip_next      = source_ip_reg;
        destination_ip_next = destination_ip_reg;
        if (cfg_we && (cfg_index == REG_SOURCE_IP))
        begin
            source_ip_next = cfg_data[31:0];
        end
        if (cfg_we && (cfg_index == REG_DESTINATION_IP))
        begin
            destination_ip_next = cfg_data[31:0];
        end
        ip_sum_next = IP_CONST_SUM
                    + 20'(source_ip_next[31:16]) + 20'(source_ip_next[15:0])
                    + 20'(destination_ip_next[31:16]) + 20'(destination_ip_next[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg       <= '0;
            destination_mac_reg  <= '0;
            source_ip_reg        <= '0;
            destination_ip_reg   <= '0;
            source_port_reg      <= '0;
            destination_port_reg <= '0;
            frame_capacity_reg   <= CAPACITY_RESET;
            ip_sum_reg           <= IP_CONST_SUM;
        end
        else
        begin
            ip_sum_reg <= ip_sum_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SOURCE_MAC:       source_mac_reg       <= cfg_data;
                    REG_DESTINATION_MAC:  destination_mac_reg  <= cfg_data;
                    REG_SOURCE_IP:        source_ip_reg        <= cfg_data[31:0];
                    REG_DESTINATION_IP:   destination_ip_reg   <= cfg_data[31:0];
                    REG_SOURCE_PORT:      source_port_reg      <= cfg_data[15:0];
                    REG_DESTINATION_PORT: destination_port_reg <= cfg_data[15:0];
                    REG_FRAME_CAPACITY:   frame_capacity_reg   <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.source_mac       = source_mac_reg;
    assign cfg.destination_mac  = destination_mac_reg;
    assign cfg.source_ip        = source_ip_reg;
    assign cfg.destination_ip   = destination_ip_reg;
    assign cfg.source_port      = source_port_reg;
    assign cfg.destination_port = destination_port_reg;
    assign cfg.frame_capacity   = frame_capacity_reg;
    assign cfg.ip_sum           = ip_sum_reg;

endmodule

// ===== rtl/iufb_hdr_mux.sv =====
`timescale 1ns / 1ps
// ============================================================================
// iufb_hdr_mux
// Selects one header byte by its position in the 42-byte header.
// ============================================================================
module iufb_hdr_mux (
    input  iufb_pkg::cfg_t cfg,
    input  iufb_pkg::hdr_t hdr,
    input  logic [5:0]     idx,
    output logic [7:0]     hdr_byte
);
    import iufb_pkg::*;

    always_comb
    begin
        case (idx) inside
            [6'd0:6'd5]:   hdr_byte = 8'(cfg.destination_mac >> {(6'd5 - idx), 3'b000});
            [6'd6:6'd11]:  hdr_byte = 8'(cfg.source_mac >> {(6'd11 - idx), 3'b000});
            6'd12:         hdr_byte = ETH_TYPE_HI;
            6'd13:         hdr_byte = ETH_TYPE_LO;
            6'd14:         hdr_byte = IP_VER_IHL;
            6'd16:         hdr_byte = {5'd0, hdr.ip_len[10:8]};
            6'd17:         hdr_byte = hdr.ip_len[7:0];
            6'd22:         hdr_byte = IP_TTL;
            6'd23:         hdr_byte = IP_PROTO_UDP;
            6'd24:         hdr_byte = hdr.checksum[15:8];
            6'd25:         hdr_byte = hdr.checksum[7:0];
            [6'd26:6'd29]: hdr_byte = 8'(cfg.source_ip >> {(6'd29 - idx), 3'b000});
            [6'd30:6'd33]: hdr_byte = 8'(cfg.destination_ip >> {(6'd33 - idx), 3'b000});
            6'd34:         hdr_byte = cfg.source_port[15:8];
            6'd35:         hdr_byte = cfg.source_port[7:0];
            6'd36:         hdr_byte = cfg.destination_port[15:8];
            6'd37:         hdr_byte = cfg.destination_port[7:0];
            6'd38:         hdr_byte = {5'd0, hdr.udp_len[10:8]};
            6'd39:         hdr_byte = hdr.udp_len[7:0];
            default:       hdr_byte = 8'd0;
        endcase
    end

endmodule

// ===== rtl/ipv4_udp_frame_builder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ipv4_udp_frame_builder
// Builds Ethernet II / IPv4 / UDP frames from start and payload words.
// ============================================================================
// Payload word: input buffer, then output register; one word per cycle
// sustained while the output is not stalled. Start word: loads the header,
// then 42 header words at one per cycle while not stalled; one more input
// word is buffered, after that input is held off until the burst ends.
// Rejection: one word, from the input buffer through the output register.
// Reset: asynchronous, clears config (capacity 1514), frame state and valids.
module ipv4_udp_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // payload_length[10:0], payload_byte[18:11]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_byte[7:0], frame_length[18:8]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import iufb_pkg::*;

    cfg_t   cfg;
    hdr_t   hdr_reg;
    hdr_t   hdr_next;
    state_t state_reg;
    state_t state_next;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_op_reg;
    logic [10:0] in_len_reg;
    logic [7:0]  in_byte_reg;

    logic [5:0]  hdr_idx_reg;
    logic [5:0]  hdr_idx_next;
    logic [10:0] remaining_reg;
    logic [10:0] remaining_next;
    logic        frame_active_reg;
    logic        frame_active_next;
    logic [10:0] cur_len_reg;
    logic [10:0] cur_len_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        out_status_reg;
    logic        out_status_next;
    logic [10:0] out_flen_reg;
    logic [10:0] out_flen_next;

    logic        s_accept;
    logic        consume;
    logic        emit;
    logic        can_emit;
    logic [7:0]  hdr_byte;
    logic [11:0] flen;
    logic        reject;
    logic [19:0] sum20;
    logic [16:0] fold1;
    logic [15:0] fold2;

    iufb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iufb_hdr_mux u_hdr (
        .cfg      (cfg),
        .hdr      (hdr_reg),
        .idx      (hdr_idx_reg),
        .hdr_byte (hdr_byte)
    );

    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // length checks and IPv4 header checksum for the buffered start word
    always_comb
    begin
        flen   = 12'(in_len_reg) + 12'(HDR_LEN);
        reject = (in_len_reg > 11'(MAX_PAYLOAD)) || (flen > {1'b0, cfg.frame_capacity})
               || (flen > 12'(MAX_FRAME));
        sum20  = cfg.ip_sum + 20'(in_len_reg) + 20'(IP_HDR_LEN + UDP_HDR_LEN);
        fold1  = 17'(sum20[15:0]) + 17'(sum20[19:16]);
        fold2  = fold1[15:0] + 16'(fold1[16]);
    end

    always_comb
    begin
        state_next        = state_reg;
        hdr_next          = hdr_reg;
        hdr_idx_next      = hdr_idx_reg;
        remaining_next    = remaining_reg;
        frame_active_next = frame_active_reg;
        cur_len_next      = cur_len_reg;
        consume           = 1'b0;
        emit              = 1'b0;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;
        out_flen_next     = out_flen_reg;

        unique case (state_reg)
            ST_HEADER:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    out_byte_next   = hdr_byte;
                    out_last_next   = (hdr_idx_reg == 6'(HDR_LEN - 1)) && (remaining_reg == '0);
                    out_status_next = STATUS_OK;
                    out_flen_next   = cur_len_reg;
                    hdr_idx_next    = hdr_idx_reg + 6'd1;
                    if (hdr_idx_reg == 6'(HDR_LEN - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (in_valid_reg)
                begin
                    if (in_op_reg == OP_START)
                    begin
                        if (reject)
                        begin
                            if (can_emit)
                            begin
                                consume           = 1'b1;
                                emit              = 1'b1;
                                out_byte_next     = 8'd0;
                                out_last_next     = 1'b1;
                                out_status_next   = STATUS_REJECT;
                                out_flen_next     = 11'd0;
                                frame_active_next = 1'b0;
                                remaining_next    = '0;
                                cur_len_next      = '0;
                            end
                        end
                        else
                        begin
                            consume           = 1'b1;
                            hdr_next.ip_len   = in_len_reg + 11'(IP_HDR_LEN + UDP_HDR_LEN);
                            hdr_next.udp_len  = in_len_reg + 11'(UDP_HDR_LEN);
                            hdr_next.checksum = ~fold2;
                            frame_active_next = (in_len_reg != '0);
                            remaining_next    = in_len_reg;
                            cur_len_next      = flen[10:0];
                            hdr_idx_next      = '0;
                            state_next        = ST_HEADER;
                        end
                    end
                    else if (frame_active_reg && (remaining_reg != '0))
                    begin
                        if (can_emit)
                        begin
                            consume         = 1'b1;
                            emit            = 1'b1;
                            out_byte_next   = in_byte_reg;
                            out_last_next   = (remaining_reg == 11'd1);
                            out_status_next = STATUS_OK;
                            out_flen_next   = cur_len_reg;
                            remaining_next  = remaining_reg - 11'd1;
                            if (remaining_reg == 11'd1)
                            begin
                                frame_active_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        // payload word outside a frame is dropped
                        consume           = 1'b1;
                        frame_active_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            hdr_idx_reg      <= '0;
            remaining_reg    <= '0;
            frame_active_reg <= 1'b0;
            cur_len_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            hdr_idx_reg      <= hdr_idx_next;
            remaining_reg    <= remaining_next;
            frame_active_reg <= frame_active_next;
            cur_len_reg      <= cur_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg   <= s_axis_tuser;
            in_len_reg  <= s_axis_tdata[10:0];
            in_byte_reg <= s_axis_tdata[18:11];
        end
        hdr_reg        <= hdr_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        out_flen_reg   <= out_flen_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_flen_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEADER) |-> (hdr_idx_reg < 6'(HDR_LEN)))
        else $error("header index out of range");

    a_hdr_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEADER) |-> !consume)
        else $error("input consumed during header burst");

    a_hdr_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEADER && can_emit) |=> out_valid_reg)
        else $error("header byte not emitted");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_REJECT) |-> (out_last_reg && out_flen_reg == '0))
        else $error("rejection word malformed");

    a_active_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        frame_active_reg |-> (remaining_reg != '0))
        else $error("active frame with no payload due");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the IPv4/UDP frame builder. Start and payload words
// are fed through the input stream while an in-bench model of the header
// builder predicts every output word. Directed tests cover the reset register
// values, the length limits and the register extremes. Random phases then run
// well-formed frames with some truncated, overlong and stray traffic, with
// random gaps and stalls on both streams in all but the last phase.
// ============================================================================
module tb_top;

    import iufb_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int QUIET_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last;
        logic        status;
        logic [10:0] frame_length;
    } frame_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = OP_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = REG_SOURCE_MAC;
    logic [47:0] cfg_data      = '0;

    // register shadow
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [10:0] capacity;

    // frame tracking
    logic [10:0] bytes_due;
    logic        in_frame;
    logic [10:0] active_frame_len;

    frame_word_t expected_words[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          useful_words   = 0;
    bit          src_idle_on    = 1'b1;
    bit          sink_stall_on  = 1'b1;

    ipv4_udp_frame_builder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_stall_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_words
        frame_word_t got;
        frame_word_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame_byte   = m_axis_tdata[7:0];
            got.frame_length = m_axis_tdata[18:8];
            got.last         = m_axis_tlast;
            got.status       = m_axis_tuser;
            if (expected_words.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected word byte %h last %b status %b len %0d",
                             $realtime, got.frame_byte, got.last, got.status,
                             got.frame_length);
                mismatch_count++;
            end
            else
            begin
                exp = expected_words.pop_front();
                if (got.frame_byte !== exp.frame_byte || got.last !== exp.last ||
                    got.status !== exp.status || got.frame_length !== exp.frame_length)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                                 $realtime, exp.frame_byte, exp.last, exp.status,
                                 exp.frame_length, got.frame_byte, got.last,
                                 got.status, got.frame_length);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void push_word(input logic [7:0] b, input logic last,
                                      input logic status, input logic [10:0] flen);
        frame_word_t w;
        w.frame_byte   = b;
        w.last         = last;
        w.status       = status;
        w.frame_length = flen;
        expected_words.push_back(w);
    endfunction

    // Returns 1 when the word produces output.
    function automatic bit predict_frame_words(input logic op, input logic [10:0] plen,
                                               input logic [7:0] pbyte);
        logic [7:0]  hdr [HDR_LEN];
        logic [15:0] udp_len;
        logic [15:0] ip_len;
        logic [31:0] sum;
        int          flen;
        int          i;
        if (op == OP_PAYLOAD)
        begin
            if (!in_frame || bytes_due == 0)
            begin
                in_frame = 1'b0;
                return 1'b0;
            end
            bytes_due = bytes_due - 1'b1;
            push_word(pbyte, bytes_due == 0, STATUS_OK, active_frame_len);
            if (bytes_due == 0)
                in_frame = 1'b0;
            return 1'b1;
        end
        udp_len   = 16'(UDP_HDR_LEN + int'(plen));
        ip_len    = 16'(IP_HDR_LEN + int'(udp_len));
        flen      = ETH_HDR_LEN + int'(ip_len);
        in_frame  = 1'b0;
        bytes_due = '0;
        if (int'(plen) > MAX_PAYLOAD || flen > int'(capacity) || flen > MAX_FRAME)
        begin
            active_frame_len = '0;
            push_word(8'h00, 1'b1, STATUS_REJECT, 11'd0);
            return 1'b1;
        end
        for (i = 0; i < 6; i++)
        begin
            hdr[i]     = dst_mac[47 - 8 * i -: 8];
            hdr[6 + i] = src_mac[47 - 8 * i -: 8];
        end
        hdr[12] = ETH_TYPE_HI;
        hdr[13] = ETH_TYPE_LO;
        hdr[14] = IP_VER_IHL;
        hdr[15] = 8'h00;
        hdr[16] = ip_len[15:8];
        hdr[17] = ip_len[7:0];
        hdr[18] = 8'h00;
        hdr[19] = 8'h00;
        hdr[20] = 8'h00;
        hdr[21] = 8'h00;
        hdr[22] = IP_TTL;
        hdr[23] = IP_PROTO_UDP;
        hdr[24] = 8'h00;
        hdr[25] = 8'h00;
        for (i = 0; i < 4; i++)
        begin
            hdr[26 + i] = src_ip[31 - 8 * i -: 8];
            hdr[30 + i] = dst_ip[31 - 8 * i -: 8];
        end
        sum = '0;
        for (i = 14; i < 34; i += 2)
            sum = sum + 32'({hdr[i], hdr[i + 1]});
        while (sum[31:16] != 0)
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        sum     = ~sum;
        hdr[24] = sum[15:8];
        hdr[25] = sum[7:0];
        hdr[34] = udp_sport[15:8];
        hdr[35] = udp_sport[7:0];
        hdr[36] = udp_dport[15:8];
        hdr[37] = udp_dport[7:0];
        hdr[38] = udp_len[15:8];
        hdr[39] = udp_len[7:0];
        hdr[40] = 8'h00;
        hdr[41] = 8'h00;
        active_frame_len = flen[10:0];
        bytes_due        = plen;
        in_frame         = plen != 0;
        for (i = 0; i < HDR_LEN; i++)
            push_word(hdr[i], i == HDR_LEN - 1 && plen == 0, STATUS_OK, flen[10:0]);
        return 1'b1;
    endfunction

    task automatic send_word(input logic op, input logic [10:0] plen,
                             input logic [7:0] pbyte);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, pbyte, plen};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_frame_words(op, plen, pbyte))
            useful_words++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_SOURCE_MAC:       src_mac   = value;
            REG_DESTINATION_MAC:  dst_mac   = value;
            REG_SOURCE_IP:        src_ip    = value[31:0];
            REG_DESTINATION_IP:   dst_ip    = value[31:0];
            REG_SOURCE_PORT:      udp_sport = value[15:0];
            REG_DESTINATION_PORT: udp_dport = value[15:0];
            REG_FRAME_CAPACITY:   capacity  = value[10:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [47:0] smac, input logic [47:0] dmac,
                                input logic [31:0] sip, input logic [31:0] dip,
                                input logic [15:0] sport, input logic [15:0] dport,
                                input logic [10:0] cap);
        write_reg(REG_SOURCE_MAC, smac);
        write_reg(REG_DESTINATION_MAC, dmac);
        write_reg(REG_SOURCE_IP, {16'b0, sip});
        write_reg(REG_DESTINATION_IP, {16'b0, dip});
        write_reg(REG_SOURCE_PORT, {32'b0, sport});
        write_reg(REG_DESTINATION_PORT, {32'b0, dport});
        write_reg(REG_FRAME_CAPACITY, {37'b0, cap});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_word(OP_PAYLOAD, 11'h7ff, 8'hff);              // stray after reset
        send_word(OP_START, 11'd0, 8'hff);                  // header only
        send_word(OP_START, 11'(MAX_PAYLOAD), 8'h00);       // exactly full frame
        send_word(OP_PAYLOAD, 11'd0, 8'h00);
        send_word(OP_PAYLOAD, 11'h7ff, 8'hff);
        send_word(OP_START, 11'(MAX_PAYLOAD + 1), 8'h00);   // abandons, then too long
        send_word(OP_PAYLOAD, 11'd0, 8'h11);                // dropped
        send_word(OP_START, 11'd3, 8'h00);
        send_word(OP_PAYLOAD, 11'd0, 8'h00);
        send_word(OP_PAYLOAD, 11'h555, 8'hff);
        send_word(OP_PAYLOAD, 11'h2aa, 8'ha5);
        send_word(OP_PAYLOAD, 11'd0, 8'h3c);                // past end, dropped
        send_word(OP_START, 11'd2047, 8'h00);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        program_regs('1, '1, '1, '1, '1, '1, 11'd2047);
        send_word(OP_START, 11'(MAX_PAYLOAD), 8'h00);
        send_word(OP_PAYLOAD, 11'd0, 8'h5a);
        send_word(OP_START, 11'd1, 8'h00);
        send_word(OP_PAYLOAD, 11'd0, 8'hc3);
        send_word(OP_START, 11'd0, 8'h00);
        wait_idle();
        program_regs('0, '0, '0, '0, '0, '0, 11'd0);
        send_word(OP_START, 11'd0, 8'h00);            // nothing fits
        wait_idle();
        program_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
                     $urandom, 16'($urandom), 16'($urandom), 11'(HDR_LEN));
        send_word(OP_START, 11'd0, 8'h00);
        send_word(OP_START, 11'd1, 8'h00);
        wait_idle();
        program_regs(48'h0123_4567_89ab, 48'hfedc_ba98_7654, 32'hc0a8_0001,
                     32'hc0a8_00fe, 16'd1024, 16'd53, 11'(HDR_LEN + 1));
        send_word(OP_START, 11'd1, 8'h00);
        send_word(OP_PAYLOAD, 11'd0, 8'h80);
        wait_idle();
    endtask

    task automatic test_random_frames(input int word_budget, input logic [10:0] cap);
        int first;
        int r;
        int plen;
        int nbytes;
        int room;
        program_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
                     $urandom, 16'($urandom), 16'($urandom), cap);
        first = useful_words;
        while (useful_words - first < word_budget)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_word(OP_PAYLOAD, 11'($urandom), 8'($urandom));
            else if (r == 1)
                send_word(OP_START, 11'($urandom_range(MAX_PAYLOAD + 1, 2047)),
                          8'($urandom));
            else
            begin
                room = int'(capacity) - HDR_LEN;
                if (r == 2 && room >= 0 && room <= MAX_PAYLOAD)
                    plen = room + $urandom_range(0, 1);
                else if (r < 8)
                    plen = $urandom_range(9, 40);
                else
                    plen = $urandom_range(0, 8);
                send_word(OP_START, 11'(plen), 8'($urandom));
                nbytes = plen;
                if (nbytes > 48)
                    nbytes = $urandom_range(0, 8);    // long frames cut short
                else if ($urandom_range(0, 7) == 0)
                    nbytes = $urandom_range(0, plen);
                else if ($urandom_range(0, 7) == 0)
                    nbytes = plen + $urandom_range(1, 3);
                repeat (nbytes) send_word(OP_PAYLOAD, 11'($urandom), 8'($urandom));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        src_mac          = '0;
        dst_mac          = '0;
        src_ip           = '0;
        dst_ip           = '0;
        udp_sport        = '0;
        udp_dport        = '0;
        capacity         = CAPACITY_RESET;
        bytes_due        = '0;
        in_frame         = 1'b0;
        active_frame_len = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_frames(35, CAPACITY_RESET);
        test_random_frames(35, 11'($urandom_range(HDR_LEN, 300)));
        test_random_frames(35, 11'd2047);
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        test_random_frames(35, 11'($urandom_range(HDR_LEN, MAX_FRAME)));
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iufb_pkg.sv
rtl/iufb_cfg_regs.sv
rtl/iufb_hdr_mux.sv
rtl/ipv4_udp_frame_builder.sv
test/tb_top.sv
